FILE: hdl/rc_ctrl_pkg.sv
// shared widths, register codes and fixed-point constants for the rc steering/throttle controller
`default_nettype none

package rc_ctrl_pkg;

   // signed stepper count width (8..16)
   localparam int COUNT_BITS = 13;

   localparam int DUTY_BITS  = 17;
   localparam int POS_BITS   = 11;
   localparam int HOLD_BITS  = 11;
   localparam int DEAD_BITS  = 10;
   localparam int LIMIT_BITS = 11;
   localparam int DRIVE_BITS = 7;
   localparam int OVR_BITS   = 4;
   localparam int GOAL_BITS  = 13;
   localparam int SUM_BITS   = ((COUNT_BITS > GOAL_BITS) ? COUNT_BITS : GOAL_BITS) + 1;
   localparam int CNT_MAX    = (2 ** (COUNT_BITS - 1)) - 1;
   localparam int CNT_MIN    = -(2 ** (COUNT_BITS - 1));

   // pipeline: input, averages, scaled products, quotients, mapped values, goal, result
   localparam int STAGES = 7;

   // register file
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SWITCH_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THROTTLE_MINIMUM = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEERING_MINIMUM = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_WINDOW      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEAD_ZONE        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TURN_LIMIT       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BRAKE_TARGET     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DRIVE_LEVEL      = 3'd7;

   localparam logic [DUTY_BITS-1:0]  RST_SWITCH_THRESHOLD = 17'd9008;
   localparam logic [DUTY_BITS-1:0]  RST_THROTTLE_MINIMUM = 17'd5563;
   localparam logic [DUTY_BITS-1:0]  RST_STEERING_MINIMUM = 17'd7462;
   localparam logic [HOLD_BITS-1:0]  RST_HOLD_WINDOW      = 11'd32;
   localparam logic [DEAD_BITS-1:0]  RST_DEAD_ZONE        = 10'd32;
   localparam logic [LIMIT_BITS-1:0] RST_TURN_LIMIT       = 11'd707;
   localparam logic [LIMIT_BITS-1:0] RST_BRAKE_TARGET     = 11'd1412;
   localparam logic [DRIVE_BITS-1:0] RST_DRIVE_LEVEL      = 7'd20;

   localparam logic [DUTY_BITS-1:0] RST_KILL_AVERAGE     = 17'd5563;
   localparam logic [DUTY_BITS-1:0] RST_BRAKE_AVERAGE    = 17'd5563;
   localparam logic [DUTY_BITS-1:0] RST_STEER_AVERAGE    = 17'd10638;
   localparam logic [DUTY_BITS-1:0] RST_THROTTLE_AVERAGE = 17'd5563;

   // slow filter: floor((100*avg + x) / 101) as multiply by 2^31/101 rounded up
   localparam int AVG_SUM_BITS   = 24;
   localparam int AVG_RECIP_BITS = 25;
   localparam int AVG_PROD_BITS  = AVG_SUM_BITS + AVG_RECIP_BITS;
   localparam int AVG_SHIFT      = 31;
   localparam logic [6:0] AVG_WEIGHT = 7'd100;
   localparam logic [AVG_RECIP_BITS-1:0] AVG_RECIP = 25'd21262215;

   // throttle: |d|*1000/689, reciprocal 2^37/689 rounded up
   localparam int THR_MAG_BITS   = 27;
   localparam int THR_RECIP_BITS = 28;
   localparam int THR_PROD_BITS  = THR_MAG_BITS + THR_RECIP_BITS;
   localparam int THR_SHIFT      = 37;
   localparam int THR_QUO_BITS   = THR_PROD_BITS - THR_SHIFT;
   localparam logic [9:0] THR_SCALE = 10'd1000;
   localparam logic [THR_RECIP_BITS-1:0] THR_RECIP = 28'd199475985;
   localparam int THR_OFFSET = 1800;
   localparam int DUTY_FULL  = 100000;

   // steering: |d|*1600/6351, reciprocal 2^41/6351 rounded up
   localparam int STR_MAG_BITS   = 28;
   localparam int STR_RECIP_BITS = 29;
   localparam int STR_PROD_BITS  = STR_MAG_BITS + STR_RECIP_BITS;
   localparam int STR_SHIFT      = 41;
   localparam int STR_QUO_BITS   = STR_PROD_BITS - STR_SHIFT;
   localparam logic [10:0] STR_SCALE = 11'd1600;
   localparam logic [STR_RECIP_BITS-1:0] STR_RECIP = 29'd346248348;
   localparam int POS_FULL   = 1600;
   localparam int POS_CENTRE = 800;

   localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = 7'd100;
   localparam logic [OVR_BITS-1:0]   OVR_ALL   = 4'hF;

endpackage

`default_nettype wire

FILE: hdl/rc_pwm_to_throttle_and_stepper_ctrl_top.sv
// rc duty samples to throttle duty, relay enable and stepper target/direction/drive
// an accepted transaction moves through the input, average, product, quotient, mapped, goal and
// result registers to rsp_valid; throughput: one transaction per cycle unless rsp_ready
// stalls the seven-register pipeline (skid-free bubble collapse); each filter and hold state
// sits in a single stage; reset (synchronous, active high) empties the pipeline, restores all
// csr values and the filter averages, held position and last direction to their defaults
`default_nettype none

module rc_pwm_to_throttle_and_stepper_ctrl_top import rc_ctrl_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input samples
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [DUTY_BITS-1:0]         req_kill_duty,
   input  wire logic [DUTY_BITS-1:0]         req_steer_duty,
   input  wire logic [DUTY_BITS-1:0]         req_throttle_duty,
   input  wire logic [DUTY_BITS-1:0]         req_brake_duty,
   input  wire logic signed [COUNT_BITS-1:0] req_step_count,
   input  wire logic                         req_allow_cw,
   input  wire logic                         req_allow_ccw,
   input  wire logic [OVR_BITS-1:0]          req_override_bits,
   // results
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [DUTY_BITS-1:0]              rsp_throttle_out,
   output logic                              rsp_relays_on,
   output logic signed [COUNT_BITS-1:0]      rsp_target_counts,
   output logic                              rsp_stepper_dir,
   output logic [DRIVE_BITS-1:0]             rsp_stepper_drive,
   // register port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]          csr_prdata,
   output logic                              csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [DUTY_BITS-1:0]  switch_threshold_ff;
   logic [DUTY_BITS-1:0]  throttle_minimum_ff;
   logic [DUTY_BITS-1:0]  steering_minimum_ff;
   logic [HOLD_BITS-1:0]  hold_window_ff;
   logic [DEAD_BITS-1:0]  dead_zone_ff;
   logic [LIMIT_BITS-1:0] turn_limit_ff;
   logic [LIMIT_BITS-1:0] brake_target_ff;
   logic [DRIVE_BITS-1:0] drive_level_ff;

   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_threshold_ff <= RST_SWITCH_THRESHOLD;
         throttle_minimum_ff <= RST_THROTTLE_MINIMUM;
         steering_minimum_ff <= RST_STEERING_MINIMUM;
         hold_window_ff      <= RST_HOLD_WINDOW;
         dead_zone_ff        <= RST_DEAD_ZONE;
         turn_limit_ff       <= RST_TURN_LIMIT;
         brake_target_ff     <= RST_BRAKE_TARGET;
         drive_level_ff      <= RST_DRIVE_LEVEL;
      end else if (csr_write) begin
         case (csr_index)
            REG_SWITCH_THRESHOLD: switch_threshold_ff <= csr_pwdata[DUTY_BITS-1:0];
            REG_THROTTLE_MINIMUM: throttle_minimum_ff <= csr_pwdata[DUTY_BITS-1:0];
            REG_STEERING_MINIMUM: steering_minimum_ff <= csr_pwdata[DUTY_BITS-1:0];
            REG_HOLD_WINDOW:      hold_window_ff      <= csr_pwdata[HOLD_BITS-1:0];
            REG_DEAD_ZONE:        dead_zone_ff        <= csr_pwdata[DEAD_BITS-1:0];
            REG_TURN_LIMIT:       turn_limit_ff       <= csr_pwdata[LIMIT_BITS-1:0];
            REG_BRAKE_TARGET:     brake_target_ff     <= csr_pwdata[LIMIT_BITS-1:0];
            REG_DRIVE_LEVEL:      drive_level_ff      <= csr_pwdata[DRIVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SWITCH_THRESHOLD: csr_prdata = CSR_DATA_BITS'(switch_threshold_ff);
         REG_THROTTLE_MINIMUM: csr_prdata = CSR_DATA_BITS'(throttle_minimum_ff);
         REG_STEERING_MINIMUM: csr_prdata = CSR_DATA_BITS'(steering_minimum_ff);
         REG_HOLD_WINDOW:      csr_prdata = CSR_DATA_BITS'(hold_window_ff);
         REG_DEAD_ZONE:        csr_prdata = CSR_DATA_BITS'(dead_zone_ff);
         REG_TURN_LIMIT:       csr_prdata = CSR_DATA_BITS'(turn_limit_ff);
         REG_BRAKE_TARGET:     csr_prdata = CSR_DATA_BITS'(brake_target_ff);
         REG_DRIVE_LEVEL:      csr_prdata = CSR_DATA_BITS'(drive_level_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- pipeline control
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] stg_ready;
   logic [STAGES-1:0] stg_load;

   // a stage takes a new transaction when it is empty or its occupant moves on
   always_comb begin
      stg_ready[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stg_ready[i] = !vld_ff[i] || stg_ready[i+1];
      end
      stg_load[0] = req_valid && stg_ready[0];
      for (int i = 1; i < STAGES; i++) begin
         stg_load[i] = vld_ff[i-1] && stg_ready[i];
      end
      for (int i = 0; i < STAGES - 1; i++) begin
         vld_in[i] = stg_load[i] || (vld_ff[i] && !stg_ready[i+1]);
      end
      vld_in[STAGES-1] = stg_load[STAGES-1] || (vld_ff[STAGES-1] && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stg_ready[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // ------------------------------------------------------- stage 1: input
   logic [DUTY_BITS-1:0]         s1_kill_ff, s1_steer_ff, s1_thr_ff, s1_brake_ff;
   logic signed [COUNT_BITS-1:0] s1_count_ff;
   logic                         s1_cw_ff, s1_ccw_ff;
   logic [OVR_BITS-1:0]          s1_ovr_ff;

   always_ff @(posedge clock) begin
      if (stg_load[0]) begin
         s1_kill_ff  <= req_kill_duty;
         s1_steer_ff <= req_steer_duty;
         s1_thr_ff   <= req_throttle_duty;
         s1_brake_ff <= req_brake_duty;
         s1_count_ff <= req_step_count;
         s1_cw_ff    <= req_allow_cw;
         s1_ccw_ff   <= req_allow_ccw;
         s1_ovr_ff   <= req_override_bits;
      end
   end

   // ------------------------------------------------- stage 2: filter averages
   logic [DUTY_BITS-1:0]     kill_avg_ff, brake_avg_ff, steer_avg_ff, thr_avg_ff;
   logic [DUTY_BITS-1:0]     kill_avg_in, brake_avg_in, steer_avg_in, thr_avg_in;
   logic [AVG_SUM_BITS-1:0]  kill_sum, brake_sum;
   logic [AVG_PROD_BITS-1:0] kill_prod, brake_prod;
   logic [DUTY_BITS:0]       steer_sum, thr_sum;

   always_comb begin
      kill_sum  = AVG_SUM_BITS'(kill_avg_ff) * AVG_SUM_BITS'(AVG_WEIGHT)
                + AVG_SUM_BITS'(s1_kill_ff);
      brake_sum = AVG_SUM_BITS'(brake_avg_ff) * AVG_SUM_BITS'(AVG_WEIGHT)
                + AVG_SUM_BITS'(s1_brake_ff);
      kill_prod  = AVG_PROD_BITS'(kill_sum) * AVG_PROD_BITS'(AVG_RECIP);
      brake_prod = AVG_PROD_BITS'(brake_sum) * AVG_PROD_BITS'(AVG_RECIP);
      kill_avg_in  = kill_prod[AVG_SHIFT +: DUTY_BITS];
      brake_avg_in = brake_prod[AVG_SHIFT +: DUTY_BITS];
      steer_sum = {1'b0, steer_avg_ff} + {1'b0, s1_steer_ff};
      thr_sum   = {1'b0, thr_avg_ff} + {1'b0, s1_thr_ff};
      steer_avg_in = steer_sum[DUTY_BITS:1];
      thr_avg_in   = thr_sum[DUTY_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kill_avg_ff  <= RST_KILL_AVERAGE;
         brake_avg_ff <= RST_BRAKE_AVERAGE;
         steer_avg_ff <= RST_STEER_AVERAGE;
         thr_avg_ff   <= RST_THROTTLE_AVERAGE;
      end else if (stg_load[1]) begin
         kill_avg_ff  <= kill_avg_in;
         brake_avg_ff <= brake_avg_in;
         steer_avg_ff <= steer_avg_in;
         thr_avg_ff   <= thr_avg_in;
      end
   end

   // the averages themselves are the stage 2 payload for the transaction in it
   logic signed [COUNT_BITS-1:0] s2_count_ff;
   logic                         s2_cw_ff, s2_ccw_ff, s2_ovr_all_ff;

   always_ff @(posedge clock) begin
      if (stg_load[1]) begin
         s2_count_ff    <= s1_count_ff;
         s2_cw_ff       <= s1_cw_ff;
         s2_ccw_ff      <= s1_ccw_ff;
         s2_ovr_all_ff  <= (s1_ovr_ff == OVR_ALL);
      end
   end

   // ------------------------------------------------ stage 3: scaled magnitudes
   logic                     thr_ge, str_ge;
   logic [DUTY_BITS-1:0]     thr_dmag, str_dmag;
   logic [THR_MAG_BITS-1:0]  thr_mag_in;
   logic [STR_MAG_BITS-1:0]  str_mag_in;

   always_comb begin
      thr_ge   = thr_avg_ff >= throttle_minimum_ff;
      str_ge   = steer_avg_ff >= steering_minimum_ff;
      thr_dmag = thr_ge ? (thr_avg_ff - throttle_minimum_ff) : (throttle_minimum_ff - thr_avg_ff);
      str_dmag = str_ge ? (steer_avg_ff - steering_minimum_ff)
                        : (steering_minimum_ff - steer_avg_ff);
      thr_mag_in = THR_MAG_BITS'(thr_dmag) * THR_MAG_BITS'(THR_SCALE);
      str_mag_in = STR_MAG_BITS'(str_dmag) * STR_MAG_BITS'(STR_SCALE);
   end

   logic [THR_MAG_BITS-1:0]      s3_thr_mag_ff;
   logic [STR_MAG_BITS-1:0]      s3_str_mag_ff;
   logic                         s3_thr_neg_ff, s3_str_neg_ff;
   logic                         s3_relays_ff, s3_brake_ff;
   logic signed [COUNT_BITS-1:0] s3_count_ff;
   logic                         s3_cw_ff, s3_ccw_ff;

   always_ff @(posedge clock) begin
      if (stg_load[2]) begin
         s3_thr_mag_ff <= thr_mag_in;
         s3_str_mag_ff <= str_mag_in;
         s3_thr_neg_ff <= !thr_ge;
         s3_str_neg_ff <= !str_ge;
         s3_relays_ff  <= (kill_avg_ff < switch_threshold_ff) || s2_ovr_all_ff;
         s3_brake_ff   <= brake_avg_ff >= switch_threshold_ff;
         s3_count_ff   <= s2_count_ff;
         s3_cw_ff      <= s2_cw_ff;
         s3_ccw_ff     <= s2_ccw_ff;
      end
   end

   // ------------------------------------------ stage 4: constant-divisor quotients
   logic [THR_PROD_BITS-1:0] thr_prod;
   logic [STR_PROD_BITS-1:0] str_prod;

   assign thr_prod = THR_PROD_BITS'(s3_thr_mag_ff) * THR_PROD_BITS'(THR_RECIP);
   assign str_prod = STR_PROD_BITS'(s3_str_mag_ff) * STR_PROD_BITS'(STR_RECIP);

   logic [THR_QUO_BITS-1:0]      s4_thr_quo_ff;
   logic [STR_QUO_BITS-1:0]      s4_str_quo_ff;
   logic                         s4_thr_neg_ff, s4_str_neg_ff;
   logic                         s4_relays_ff, s4_brake_ff;
   logic signed [COUNT_BITS-1:0] s4_count_ff;
   logic                         s4_cw_ff, s4_ccw_ff;

   always_ff @(posedge clock) begin
      if (stg_load[3]) begin
         s4_thr_quo_ff <= thr_prod[THR_SHIFT +: THR_QUO_BITS];
         s4_str_quo_ff <= str_prod[STR_SHIFT +: STR_QUO_BITS];
         s4_thr_neg_ff <= s3_thr_neg_ff;
         s4_str_neg_ff <= s3_str_neg_ff;
         s4_relays_ff  <= s3_relays_ff;
         s4_brake_ff   <= s3_brake_ff;
         s4_count_ff   <= s3_count_ff;
         s4_cw_ff      <= s3_cw_ff;
         s4_ccw_ff     <= s3_ccw_ff;
      end
   end

   // ------------------------------------------ stage 5: throttle duty and position
   logic [THR_QUO_BITS:0]   thr_up;
   logic [DUTY_BITS-1:0]    thr_out_in;
   logic [POS_BITS-1:0]     pos_in;

   always_comb begin
      thr_up = (THR_QUO_BITS + 1)'(s4_thr_quo_ff) + (THR_QUO_BITS + 1)'(THR_OFFSET);
      if (s4_thr_neg_ff) begin
         if (s4_thr_quo_ff > THR_QUO_BITS'(THR_OFFSET)) begin
            thr_out_in = '0;
         end else begin
            thr_out_in = DUTY_BITS'(THR_OFFSET) - DUTY_BITS'(s4_thr_quo_ff);
         end
      end else if (thr_up > (THR_QUO_BITS + 1)'(DUTY_FULL)) begin
         thr_out_in = DUTY_BITS'(DUTY_FULL);
      end else begin
         thr_out_in = thr_up[DUTY_BITS-1:0];
      end

      // a negative quotient truncates to zero or below, both clamp to zero
      if (s4_str_neg_ff) begin
         pos_in = '0;
      end else if (s4_str_quo_ff > STR_QUO_BITS'(POS_FULL)) begin
         pos_in = POS_BITS'(POS_FULL);
      end else begin
         pos_in = s4_str_quo_ff[POS_BITS-1:0];
      end
   end

   logic [DUTY_BITS-1:0]         s5_thr_out_ff;
   logic [POS_BITS-1:0]          s5_pos_ff;
   logic                         s5_relays_ff, s5_brake_ff;
   logic signed [COUNT_BITS-1:0] s5_count_ff;
   logic                         s5_cw_ff, s5_ccw_ff;

   always_ff @(posedge clock) begin
      if (stg_load[4]) begin
         s5_thr_out_ff <= thr_out_in;
         s5_pos_ff     <= pos_in;
         s5_relays_ff  <= s4_relays_ff;
         s5_brake_ff   <= s4_brake_ff;
         s5_count_ff   <= s4_count_ff;
         s5_cw_ff      <= s4_cw_ff;
         s5_ccw_ff     <= s4_ccw_ff;
      end
   end

   // ------------------------------------------------ stage 6: hold band and goal
   logic [HOLD_BITS-1:0]        held_pos_ff;
   logic                        in_band;
   logic [POS_BITS-1:0]         pos_used;
   logic signed [GOAL_BITS-1:0] pos_s, held_s, win_s, dz_s, tl_s, bt_s;
   logic signed [GOAL_BITS-1:0] goal_raw, goal_in;

   always_comb begin
      pos_s  = $signed(GOAL_BITS'(s5_pos_ff));
      held_s = $signed(GOAL_BITS'(held_pos_ff));
      win_s  = $signed(GOAL_BITS'(hold_window_ff));
      dz_s   = $signed(GOAL_BITS'(dead_zone_ff));
      tl_s   = $signed(GOAL_BITS'(turn_limit_ff));
      bt_s   = $signed(GOAL_BITS'(brake_target_ff));

      in_band  = (pos_s < held_s + win_s) && (pos_s > held_s - win_s);
      pos_used = in_band ? held_pos_ff : s5_pos_ff;
      goal_raw = $signed(GOAL_BITS'(pos_used)) - $signed(GOAL_BITS'(POS_CENTRE));

      if (s5_brake_ff) begin
         goal_in = (s5_count_ff >= 0) ? bt_s : -bt_s;
      end else if (goal_raw >= -dz_s && goal_raw <= dz_s) begin
         // dead zone wins even over a smaller turn limit
         goal_in = '0;
      end else if (goal_raw > tl_s) begin
         goal_in = tl_s;
      end else if (goal_raw < -tl_s) begin
         goal_in = -tl_s;
      end else begin
         goal_in = goal_raw;
      end
   end

   // held position only moves while the brake is off and the new position leaves the band
   always_ff @(posedge clock) begin
      if (reset) begin
         held_pos_ff <= '0;
      end else if (stg_load[5] && !s5_brake_ff && !in_band) begin
         held_pos_ff <= s5_pos_ff;
      end
   end

   logic signed [GOAL_BITS-1:0]  s6_goal_ff;
   logic [DUTY_BITS-1:0]         s6_thr_out_ff;
   logic                         s6_relays_ff;
   logic signed [COUNT_BITS-1:0] s6_count_ff;
   logic                         s6_cw_ff, s6_ccw_ff;

   always_ff @(posedge clock) begin
      if (stg_load[5]) begin
         s6_goal_ff    <= goal_in;
         s6_thr_out_ff <= s5_thr_out_ff;
         s6_relays_ff  <= s5_relays_ff;
         s6_count_ff   <= s5_count_ff;
         s6_cw_ff      <= s5_cw_ff;
         s6_ccw_ff     <= s5_ccw_ff;
      end
   end

   // --------------------------------------------- stage 7: target and motion
   logic                         last_dir_ff;
   logic signed [SUM_BITS-1:0]   tgt_sum, tgt_half, tgt_sat;
   logic signed [COUNT_BITS-1:0] target_in;
   logic [DRIVE_BITS-1:0]        drive_lvl, drive_in;
   logic                         dir_in;

   always_comb begin
      tgt_sum  = SUM_BITS'(s6_goal_ff) + SUM_BITS'(s6_count_ff);
      // halve rounding toward zero
      tgt_half = (tgt_sum + $signed(SUM_BITS'(tgt_sum[SUM_BITS-1]))) >>> 1;
      if (tgt_half > $signed(SUM_BITS'(CNT_MAX))) begin
         tgt_sat = SUM_BITS'(CNT_MAX);
      end else if (tgt_half < $signed(SUM_BITS'(CNT_MIN))) begin
         tgt_sat = SUM_BITS'(CNT_MIN);
      end else begin
         tgt_sat = tgt_half;
      end
      target_in = $signed(tgt_sat[COUNT_BITS-1:0]);

      drive_lvl = (drive_level_ff > DRIVE_MAX) ? DRIVE_MAX : drive_level_ff;
      if (s6_count_ff > target_in && s6_cw_ff) begin
         dir_in   = 1'b0;
         drive_in = drive_lvl;
      end else if (s6_count_ff < target_in && s6_ccw_ff) begin
         dir_in   = 1'b1;
         drive_in = drive_lvl;
      end else begin
         dir_in   = last_dir_ff;
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff <= 1'b0;
      end else if (stg_load[6]) begin
         last_dir_ff <= dir_in;
      end
   end

   logic [DUTY_BITS-1:0]         s7_thr_out_ff;
   logic                         s7_relays_ff;
   logic signed [COUNT_BITS-1:0] s7_target_ff;
   logic                         s7_dir_ff;
   logic [DRIVE_BITS-1:0]        s7_drive_ff;

   always_ff @(posedge clock) begin
      if (stg_load[6]) begin
         s7_thr_out_ff <= s6_thr_out_ff;
         s7_relays_ff  <= s6_relays_ff;
         s7_target_ff  <= target_in;
         s7_dir_ff     <= dir_in;
         s7_drive_ff   <= drive_in;
      end
   end

   assign rsp_throttle_out  = s7_thr_out_ff;
   assign rsp_relays_on     = s7_relays_ff;
   assign rsp_target_counts = s7_target_ff;
   assign rsp_stepper_dir   = s7_dir_ff;
   assign rsp_stepper_drive = s7_drive_ff;

endmodule

`default_nettype wire
